FILE: src/assembler_label_table_builder_macros.svh
// Assertion helpers for the label table builder.
`ifndef ASSEMBLER_LABEL_TABLE_BUILDER_MACROS_SVH
`define ASSEMBLER_LABEL_TABLE_BUILDER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define LBT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("label table builder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define LBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("label table builder: next-cycle check failed");

`else

`define LBT_ASSERT_NOW(label, clk, rst, ante, cons)
`define LBT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: src/lbt_pkg.sv
`default_nettype none

package lbt_pkg;

   localparam int MAX_ENTRIES    = 16;
   localparam int MAX_NAME_CHARS = 19;
   localparam int ADDRESS_BITS   = 16;

   localparam int SLOT_BITS     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_BITS    = $clog2(MAX_ENTRIES + 1);
   localparam int CHAR_IDX_BITS = (MAX_NAME_CHARS > 1) ? $clog2(MAX_NAME_CHARS) : 1;
   localparam int LEN_BITS      = $clog2(MAX_NAME_CHARS + 1);
   localparam int MEM_ADDR_BITS = SLOT_BITS + CHAR_IDX_BITS;
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] PHASE_TOKEN = 2'd0;
   localparam logic [1:0] PHASE_LABEL = 2'd1;
   localparam logic [1:0] PHASE_PLAIN = 2'd2;

   localparam logic [1:0] ST_RECORDED  = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_TOO_LONG  = 2'd3;

   typedef struct packed {
      logic                     wr_byte;
      logic                     rd_byte;
      logic                     wr_len;
      logic [SLOT_BITS-1:0]     slot;
      logic [CHAR_IDX_BITS-1:0] idx;
      logic [LEN_BITS-1:0]      len;
   } store_ctl_type;

endpackage

`default_nettype wire

FILE: src/lbt_scanner.sv
`default_nettype none

module lbt_scanner (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                char_valid,
   input  wire  [7:0]                         char_in,
   input  wire                                clear_line,
   input  wire  [lbt_pkg::CHAR_IDX_BITS-1:0]  rd_idx,
   output logic [7:0]                         rd_char,
   output logic [lbt_pkg::LEN_BITS-1:0]       tok_len,
   output logic [1:0]                         phase,
   output logic                               overflow
);
   import lbt_pkg::*;

   logic [7:0]          tok_ff [MAX_NAME_CHARS];
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic [1:0]          phase_ff, phase_in;
   logic                ovf_ff, ovf_in;
   logic                store_char;

   always_comb begin
      len_in     = len_ff;
      phase_in   = phase_ff;
      ovf_in     = ovf_ff;
      store_char = 1'b0;
      if (clear_line) begin
         len_in   = '0;
         phase_in = PHASE_TOKEN;
         ovf_in   = 1'b0;
      end else if (char_valid && phase_ff == PHASE_TOKEN) begin
         if (char_in == CH_COLON) begin
            phase_in = PHASE_LABEL;
         end else if (char_in == CH_SPACE || char_in == CH_NUL) begin
            phase_in = PHASE_PLAIN;
         end else if (len_ff < LEN_BITS'(MAX_NAME_CHARS)) begin
            store_char = 1'b1;
            len_in     = len_ff + LEN_BITS'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         phase_ff <= PHASE_TOKEN;
         ovf_ff   <= 1'b0;
      end else begin
         len_ff   <= len_in;
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_char) begin
         tok_ff[len_ff[CHAR_IDX_BITS-1:0]] <= char_in;
      end
   end

   assign rd_char  = tok_ff[rd_idx];
   assign tok_len  = len_ff;
   assign phase    = phase_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

FILE: src/lbt_name_store.sv
`default_nettype none

module lbt_name_store (
   input  wire                           clock,
   input  wire  lbt_pkg::store_ctl_type  ctl,
   input  wire  [7:0]                    tok_char,
   output logic [lbt_pkg::LEN_BITS-1:0]  slot_len,
   output logic                          byte_eq
);
   import lbt_pkg::*;

   logic [7:0]          name_mem [MEM_DEPTH];
   logic [LEN_BITS-1:0] len_ff [MAX_ENTRIES];
   logic [7:0]          rd_data_ff;
   logic [MEM_ADDR_BITS-1:0] mem_addr;

   assign mem_addr = {ctl.slot, ctl.idx};

   // single-port name memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_byte) begin
         name_mem[mem_addr] <= tok_char;
      end
      if (ctl.rd_byte) begin
         rd_data_ff <= name_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_len) begin
         len_ff[ctl.slot] <= ctl.len;
      end
   end

   assign slot_len = len_ff[ctl.slot];
   // shared byte comparator: stored byte against the token byte at the same index
   assign byte_eq  = (rd_data_ff == tok_char);

endmodule

`default_nettype wire

FILE: src/assembler_label_table_builder.sv
`default_nettype none
// Label table builder, first assembler pass.
// Input: one beat per source byte on req_character with req_line_end low, and one
// beat with req_line_end high to close each line. A beat is taken when start is high
// and busy is low. Bytes and lines without a label leave busy low.
// A labelled line end with a name that fits raises busy while the stored names are
// searched by one shared byte comparator fed from a single-port name memory: per
// stored slot a length check, then per compared byte a read and a compare. A new
// name is then written one byte per cycle. A label that is too long is answered
// in the next cycle without raising busy.
// Result: one beat per labelled line, rsp_strobe high for exactly one cycle with
// rsp_status, rsp_line_address and rsp_entry_index, in the cycle after the search ends.
// The receiver cannot stall; results are never held.
// Configuration: start_address (any APB address; paddr is not decoded) loads the line
// address counter at once; write it only while busy is low and no result is pending.
// Reset (synchronous) empties the name table, clears the current line and sets the line
// address and start_address to zero.
module assembler_label_table_builder (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [7:0]  req_character,
   input  wire         req_line_end,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_line_address,
   output logic [3:0]  rsp_entry_index,
   input  wire         psel,
   input  wire         penable,
   input  wire         pwrite,
   input  wire  [1:0]  paddr,
   input  wire  [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import lbt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SLOT  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [COUNT_BITS-1:0]   slot_ff, slot_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [LEN_BITS-1:0]     idx_ff, idx_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [15:0]             start_addr_ff, start_addr_in;

   logic                    strobe_ff, strobe_in;
   logic [1:0]              status_ff, status_in;
   logic [15:0]             line_addr_ff, line_addr_in;
   logic [3:0]              index_ff, index_in;

   logic                    accept, csr_wr, clear_line, advance, last_byte;
   logic [7:0]              tok_char;
   logic [LEN_BITS-1:0]     tok_len, slot_len;
   logic [1:0]              phase;
   logic                    overflow, byte_eq;
   store_ctl_type           ctl;
   logic [COUNT_BITS-1:0]   emit_slot;
   logic [COUNT_BITS+3:0]   slot_ext;
   logic [ADDRESS_BITS+15:0] addr_ext;
   logic [ADDRESS_BITS+15:0] cfg_ext;

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite;
   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign prdata = {16'd0, start_addr_ff};

   assign last_byte = ((idx_ff + LEN_BITS'(1)) == tok_len);
   assign slot_ext  = {4'd0, emit_slot};
   assign addr_ext  = {16'd0, addr_ff};
   assign cfg_ext   = {{ADDRESS_BITS{1'b0}}, pwdata[15:0]};

   lbt_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .char_valid (accept && !req_line_end),
      .char_in    (req_character),
      .clear_line (clear_line),
      .rd_idx     (idx_ff[CHAR_IDX_BITS-1:0]),
      .rd_char    (tok_char),
      .tok_len    (tok_len),
      .phase      (phase),
      .overflow   (overflow)
   );

   lbt_name_store u_store (
      .clock    (clock),
      .ctl      (ctl),
      .tok_char (tok_char),
      .slot_len (slot_len),
      .byte_eq  (byte_eq)
   );

   always_comb begin
      state_in    = state_ff;
      slot_in     = slot_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      clear_line  = 1'b0;
      advance     = 1'b0;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      emit_slot   = '0;
      ctl.wr_byte = 1'b0;
      ctl.rd_byte = 1'b0;
      ctl.wr_len  = 1'b0;
      ctl.slot    = slot_ff[SLOT_BITS-1:0];
      ctl.idx     = idx_ff[CHAR_IDX_BITS-1:0];
      ctl.len     = tok_len;

      case (state_ff)
         S_IDLE: begin
            if (accept && req_line_end) begin
               if (phase == PHASE_LABEL && !overflow) begin
                  slot_in  = '0;
                  state_in = S_SLOT;
               end else begin
                  if (phase == PHASE_LABEL) begin
                     strobe_in = 1'b1;
                     status_in = ST_TOO_LONG;
                  end
                  advance    = 1'b1;
                  clear_line = 1'b1;
               end
            end
         end
         S_SLOT: begin
            idx_in = '0;
            if (slot_ff == count_ff) begin
               // no match among stored names
               if (count_ff == COUNT_BITS'(MAX_ENTRIES)) begin
                  strobe_in  = 1'b1;
                  status_in  = ST_FULL;
                  advance    = 1'b1;
                  clear_line = 1'b1;
                  state_in   = S_IDLE;
               end else if (tok_len == '0) begin
                  ctl.slot   = count_ff[SLOT_BITS-1:0];
                  ctl.wr_len = 1'b1;
                  count_in   = count_ff + COUNT_BITS'(1);
                  emit_slot  = count_ff;
                  strobe_in  = 1'b1;
                  status_in  = ST_RECORDED;
                  advance    = 1'b1;
                  clear_line = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_WRITE;
               end
            end else if (slot_len != tok_len) begin
               slot_in = slot_ff + COUNT_BITS'(1);
            end else if (tok_len == '0) begin
               emit_slot  = slot_ff;
               strobe_in  = 1'b1;
               status_in  = ST_DUPLICATE;
               advance    = 1'b1;
               clear_line = 1'b1;
               state_in   = S_IDLE;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctl.rd_byte = 1'b1;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            if (!byte_eq) begin
               slot_in  = slot_ff + COUNT_BITS'(1);
               state_in = S_SLOT;
            end else if (last_byte) begin
               emit_slot  = slot_ff;
               strobe_in  = 1'b1;
               status_in  = ST_DUPLICATE;
               advance    = 1'b1;
               clear_line = 1'b1;
               state_in   = S_IDLE;
            end else begin
               idx_in   = idx_ff + LEN_BITS'(1);
               state_in = S_READ;
            end
         end
         S_WRITE: begin
            ctl.slot    = count_ff[SLOT_BITS-1:0];
            ctl.wr_byte = 1'b1;
            if (last_byte) begin
               ctl.wr_len = 1'b1;
               count_in   = count_ff + COUNT_BITS'(1);
               emit_slot  = count_ff;
               strobe_in  = 1'b1;
               status_in  = ST_RECORDED;
               advance    = 1'b1;
               clear_line = 1'b1;
               state_in   = S_IDLE;
            end else begin
               idx_in = idx_ff + LEN_BITS'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      line_addr_in  = addr_ext[15:0];
      index_in      = slot_ext[3:0];
      start_addr_in = start_addr_ff;
      addr_in       = addr_ff;
      if (csr_wr) begin
         start_addr_in = pwdata[15:0];
         addr_in       = cfg_ext[ADDRESS_BITS-1:0];
      end else if (advance) begin
         addr_in = addr_ff + ADDRESS_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         addr_ff       <= '0;
         start_addr_ff <= '0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         addr_ff       <= addr_in;
         start_addr_ff <= start_addr_in;
         strobe_ff     <= strobe_in;
      end
   end

   // result payload, sampled only with the strobe
   always_ff @(posedge clock) begin
      if (strobe_in) begin
         status_ff    <= status_in;
         line_addr_ff <= line_addr_in;
         index_ff     <= index_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_line_address = line_addr_ff;
   assign rsp_entry_index  = index_ff;

`include "assembler_label_table_builder_macros.svh"

   `LBT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_BITS'(MAX_ENTRIES))
   `LBT_ASSERT_NOW(a_recorded_grows, clock, reset, rsp_strobe && rsp_status == ST_RECORDED, count_ff == $past(count_ff) + COUNT_BITS'(1))
   `LBT_ASSERT_NOW(a_full_only_when_full, clock, reset, rsp_strobe && rsp_status == ST_FULL, count_ff == COUNT_BITS'(MAX_ENTRIES))
   `LBT_ASSERT_NEXT(a_read_then_check, clock, reset, state_ff == S_READ, state_ff == S_CHECK)

endmodule

`default_nettype wire

FILE: tb/label_table_monitor.sv
module label_table_monitor
   import lbt_pkg::*;
#(
   parameter logic [1:0] START_ADDRESS_ADDR = 2'd0
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_character,
   input  logic        req_line_end,
   input  logic        rsp_strobe,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_line_address,
   input  logic [3:0]  rsp_entry_index,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic [31:0] prdata,
   input  logic        pready,
   output int unsigned outstanding,
   output int unsigned failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] line_address;
      logic [3:0]  entry_index;
   } label_result_type;

   label_result_type expected_labels[$];
   int unsigned      fault_count = 0;

   // own copy of the name table and the line being scanned
   logic [7:0]              stored_bytes [MAX_ENTRIES][MAX_NAME_CHARS];
   logic [LEN_BITS-1:0]     stored_len   [MAX_ENTRIES];
   logic [COUNT_BITS-1:0]   stored_count;
   logic [ADDRESS_BITS-1:0] line_counter;
   logic [15:0]             start_address;
   logic [7:0]              token_bytes  [MAX_NAME_CHARS];
   logic [LEN_BITS-1:0]     token_len;
   logic [1:0]              scan_phase;
   logic                    token_overflow;

   task automatic predict_label(input logic [7:0] ch, input logic line_end);
      label_result_type res;
      logic             found;
      logic             same;
      int               slot;
      int               i;
      int               j;
      if (!line_end) begin
         if (scan_phase == PHASE_TOKEN) begin
            if (ch == CH_COLON) begin
               scan_phase = PHASE_LABEL;
            end else if (ch == CH_SPACE || ch == CH_NUL) begin
               scan_phase = PHASE_PLAIN;
            end else if (token_len < MAX_NAME_CHARS) begin
               token_bytes[token_len] = ch;
               token_len++;
            end else begin
               token_overflow = 1'b1;
            end
         end
      end else begin
         if (scan_phase == PHASE_LABEL) begin
            found = 1'b0;
            slot  = 0;
            if (token_overflow) begin
               res.status = ST_TOO_LONG;
            end else begin
               for (i = 0; i < stored_count && !found; i++) begin
                  same = (stored_len[i] == token_len);
                  for (j = 0; j < token_len && same; j++) begin
                     if (stored_bytes[i][j] != token_bytes[j]) same = 1'b0;
                  end
                  if (same) begin
                     found = 1'b1;
                     slot  = i;
                  end
               end
               if (found) begin
                  res.status = ST_DUPLICATE;
               end else if (stored_count >= MAX_ENTRIES) begin
                  res.status = ST_FULL;
               end else begin
                  slot = stored_count;
                  for (j = 0; j < token_len; j++) stored_bytes[slot][j] = token_bytes[j];
                  stored_len[slot] = token_len;
                  stored_count++;
                  res.status = ST_RECORDED;
               end
            end
            res.line_address = 16'(line_counter);
            res.entry_index  = 4'(slot);
            expected_labels.push_back(res);
         end
         // every line advances the address, labelled or not
         line_counter++;
         token_len      = '0;
         scan_phase     = PHASE_TOKEN;
         token_overflow = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      label_result_type got;
      label_result_type want;
      if (reset) begin
         expected_labels.delete();
         stored_count   = '0;
         start_address  = '0;
         line_counter   = '0;
         token_len      = '0;
         scan_phase     = PHASE_TOKEN;
         token_overflow = 1'b0;
      end else begin
         // results first: a beat taken at this edge cannot have answered yet
         if (rsp_strobe) begin
            got = '{rsp_status, rsp_line_address, rsp_entry_index};
            if (expected_labels.size() == 0) begin
               $display("%0t: unexpected result status %0d address %h index %0d",
                        $time, got.status, got.line_address, got.entry_index);
               fault_count++;
            end else begin
               want = expected_labels.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, got.status);
                  fault_count++;
               end
               if (got.line_address != want.line_address) begin
                  $display("%0t: line address expected %h actual %h",
                           $time, want.line_address, got.line_address);
                  fault_count++;
               end
               if (got.entry_index != want.entry_index) begin
                  $display("%0t: entry index expected %0d actual %0d",
                           $time, want.entry_index, got.entry_index);
                  fault_count++;
               end
            end
         end
         if (start && !busy) predict_label(req_character, req_line_end);
         if (psel && penable && pready && paddr == START_ADDRESS_ADDR) begin
            if (pwrite) begin
               start_address = pwdata[15:0];
               line_counter  = ADDRESS_BITS'(pwdata[15:0]);
            end else if (prdata[15:0] != start_address) begin
               $display("%0t: start address read expected %h actual %h",
                        $time, start_address, prdata[15:0]);
               fault_count++;
            end
         end
      end
      outstanding <= expected_labels.size();
      failures    <= fault_count;
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lbt_pkg::*;

   localparam logic [1:0] START_ADDRESS_ADDR = 2'd0;
   localparam int SETTLE_CYCLES  = MAX_ENTRIES * (1 + 2 * MAX_NAME_CHARS) + MAX_NAME_CHARS + 8;
   localparam int WATCHDOG_LIMIT = 8 * SETTLE_CYCLES;
   localparam int LABEL_POOL     = 24;
   localparam int PRESSURE_BEAT  = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_character = 8'h00;
   logic        req_line_end = 1'b0;
   logic        rsp_strobe;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_line_address;
   logic [3:0]  rsp_entry_index;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = 2'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   int unsigned results_due;
   int unsigned failures;
   int unsigned beats_sent = 0;
   int unsigned sender_idle_pct = 31;
   int unsigned stall_cycles = 0;
   bit          pressure_done = 1'b0;

   logic [7:0] line_text[$];
   logic [7:0] pool_text [LABEL_POOL][MAX_NAME_CHARS];
   int         pool_len  [LABEL_POOL];

   assembler_label_table_builder i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_character    (req_character),
      .req_line_end     (req_line_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_line_address (rsp_line_address),
      .rsp_entry_index  (rsp_entry_index),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   label_table_monitor #(.START_ADDRESS_ADDR(START_ADDRESS_ADDR)) i_monitor (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_character    (req_character),
      .req_line_end     (req_line_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_line_address (rsp_line_address),
      .rsp_entry_index  (rsp_entry_index),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .outstanding      (results_due),
      .failures         (failures)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic logic [7:0] name_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_SPACE || c == CH_COLON);
      return c;
   endfunction

   task automatic append_name(input int len);
      int i;
      for (i = 0; i < len; i++) line_text.push_back(name_char());
   endtask

   task automatic append_noise(input int len);
      int i;
      for (i = 0; i < len; i++) line_text.push_back(8'($urandom_range(255)));
   endtask

   task automatic send_beat(input logic [7:0] ch, input logic line_end);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_character <= ch;
      req_line_end  <= line_end;
      do @(posedge clock); while (busy);
      beats_sent++;
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_text.size(); i++) send_beat(line_text[i], 1'b0);
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   // drop start and hold off until every result is in and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= START_ADDRESS_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_start_address(input logic [15:0] value);
      csr_access(1'b1, {16'($urandom()), value});
      csr_access(1'b0, 32'($urandom()));
   endtask

   task automatic compose_random_line();
      int kind;
      int k;
      int i;
      kind = $urandom_range(99);
      line_text = {};
      if (kind < 55) begin
         k = $urandom_range(LABEL_POOL - 1);
         for (i = 0; i < pool_len[k]; i++) line_text.push_back(pool_text[k][i]);
         line_text.push_back(CH_COLON);
         append_noise($urandom_range(3));
      end else if (kind < 65) begin
         append_name($urandom_range(MAX_NAME_CHARS + 1, MAX_NAME_CHARS + 5));
         line_text.push_back(CH_COLON);
      end else if (kind < 70) begin
         append_name(MAX_NAME_CHARS);
         line_text.push_back(CH_COLON);
         append_noise($urandom_range(2));
      end else if (kind < 85) begin
         append_name($urandom_range(6));
         line_text.push_back($urandom_range(1) ? CH_SPACE : CH_NUL);
         append_noise($urandom_range(4));
      end else if (kind < 95) begin
         append_name($urandom_range(1, 8));
      end else begin
         append_noise($urandom_range(8));
      end
   endtask

   task automatic run_random(input int unsigned until_beats);
      while (beats_sent < until_beats) begin
         if (!pressure_done && beats_sent >= PRESSURE_BEAT) begin
            settle();
            pressure_done = 1'b1;
         end
         compose_random_line();
         send_line();
      end
   endtask

   initial begin
      int i;
      int j;
      for (i = 0; i < LABEL_POOL; i++) begin
         pool_len[i] = (i < 2) ? MAX_NAME_CHARS : $urandom_range(6);
         for (j = 0; j < MAX_NAME_CHARS; j++) pool_text[i][j] = name_char();
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed lines, start address left at its reset value
      line_text = '{CH_COLON};
      send_line();
      line_text = '{8'hFF, 8'h01, CH_COLON};
      send_line();
      line_text = '{CH_COLON};
      send_line();
      line_text = '{CH_SPACE, CH_COLON};
      send_line();
      line_text = '{8'h71, CH_NUL, CH_COLON};
      send_line();
      line_text = '{8'h62, CH_COLON, CH_COLON};
      send_line();
      line_text = {};
      send_line();
      line_text = '{8'hFF, 8'h01, CH_COLON};
      send_line();

      settle();
      load_start_address(16'hFFFF);
      run_random(600);

      settle();
      sender_idle_pct = 82;
      load_start_address(16'($urandom()));
      run_random(1200);

      settle();
      sender_idle_pct = 0;
      load_start_address(16'h0000);
      run_random(1800);

      settle();
      if (results_due != 0) $display("%0t: %0d results never arrived", $time, results_due);
      if (failures == 0 && results_due == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
